>>> sv/tlw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlw_pkg
// Shared types, constants and helpers for the two-level timer wheel.
// ----------------------------------------------------------------------------
package tlw_pkg;

    localparam int NUM_TIMERS   = 64;
    localparam int FINE_SLOTS   = 50;
    localparam int COARSE_SLOTS = 60;

    localparam int ID_W      = 6;
    localparam int SLOT_W    = 6;
    localparam int MOD_W     = SLOT_W + 1;
    localparam int IDX_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int LOOP_W    = $clog2(FINE_SLOTS + 1);
    localparam int DIV_STEPS = 32;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    localparam logic [MOD_W-1:0] FINE_M   = MOD_W'(FINE_SLOTS);
    localparam logic [MOD_W-1:0] COARSE_M = MOD_W'(COARSE_SLOTS);

    localparam logic [9:0]  MICRO_RST = 10'd20;
    localparam logic [15:0] MACRO_RST = 16'd1000;
    localparam logic [21:0] SCAN_RST  = 22'd60000;

    typedef enum logic [0:0] {OP_ARM, OP_TIME} t_op;

    typedef enum logic [1:0] {CFG_MICRO, CFG_MACRO, CFG_SCAN} t_cfg_idx;

    typedef enum logic [1:0] {LVL_NONE, LVL_FINE, LVL_COARSE, LVL_OVER} t_lvl;

    typedef enum logic [1:0] {
        DIV_FINE_PASS, DIV_COARSE_PASS, DIV_FILE_FINE, DIV_FILE_COARSE
    } t_div_sel;

    typedef enum logic [1:0] {CTX_FINE, CTX_COARSE, CTX_OVER} t_ctx;

    typedef enum logic [0:0] {RET_IDLE, RET_SCAN} t_ret;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_ARM_RD,
        S_FILE_A_GO, S_FILE_A_WAIT, S_FILE_B_GO, S_FILE_B_WAIT,
        S_FDIV_GO, S_FDIV_WAIT, S_FSLOT,
        S_SCAN_RD, S_SCAN_CHK, S_SCAN_NEXT,
        S_CDIV_GO, S_CDIV_WAIT, S_CSTEP,
        S_OVCHK, S_DONE
    } t_state;

    typedef struct packed {
        logic     ld_item;
        logic     arm_write;
        logic     rd;
        logic     t_inc;
        logic     div_start;
        t_div_sel div_sel;
        logic     file_a;
        logic     file_b;
        logic     fine_setup;
        logic     fslot_adv;
        logic     fine_commit;
        logic     coarse_setup;
        logic     coarse_step;
        logic     coarse_commit;
        logic     ov_start;
        logic     emit;
        logic     flush;
        t_ctx     ctx;
    } t_cmd;

    typedef struct packed {
        logic is_arm;
        logic arm_ok;
        logic div_busy;
        logic hit;
        logic fire;
        logic f_fits;
        logic fpass_zero;
        logic cpass_end;
        logic ov_due;
        logic t_last;
        logic emit_ok;
        logic flush_ok;
    } t_stat;

    function automatic logic [SLOT_W-1:0] mod_add(
        input logic [SLOT_W-1:0] a,
        input logic [SLOT_W-1:0] b,
        input logic [MOD_W-1:0]  m
    );
        logic [MOD_W-1:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= m) begin
            s = s - m;
        end
        return s[SLOT_W-1:0];
    endfunction

endpackage

>>> sv/tlw_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlw_div
// Radix-2 restoring divider, one quotient bit per cycle, with the quotient
// reduced modulo a small number on the fly.
// ----------------------------------------------------------------------------
module tlw_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [31:0]               i_dividend,
    input  logic [15:0]               i_divisor,
    input  logic [tlw_pkg::MOD_W-1:0] i_modulus,
    output logic                      o_busy,
    output logic [31:0]               o_quot,
    output logic [15:0]               o_rem,
    output logic [tlw_pkg::SLOT_W-1:0] o_qmod
);
    import tlw_pkg::*;

    logic              r_busy;
    logic [DCNT_W-1:0] r_cnt;
    logic [31:0]       r_dvd;
    logic [31:0]       r_q;
    logic [15:0]       r_rem;
    logic [15:0]       r_div;
    logic [MOD_W-1:0]  r_mod;
    logic [SLOT_W-1:0] r_qm;

    logic [16:0]       w_trial;
    logic [16:0]       w_diff;
    logic              w_ge;
    logic [15:0]       n_rem;
    logic [MOD_W-1:0]  w_qm2;
    logic [MOD_W-1:0]  n_qm;

    assign w_trial = {r_rem, r_dvd[31]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign n_rem   = w_ge ? w_diff[15:0] : w_trial[15:0];
    assign w_qm2   = {r_qm, w_ge};
    assign n_qm    = (w_qm2 >= r_mod) ? (w_qm2 - r_mod) : w_qm2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DCNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_q   <= '0;
            r_rem <= '0;
            r_div <= i_divisor;
            r_mod <= i_modulus;
            r_qm  <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[30:0], 1'b0};
            r_q   <= {r_q[30:0], w_ge};
            r_rem <= n_rem;
            r_qm  <= n_qm[SLOT_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;
    assign o_rem  = r_rem;
    assign o_qmod = r_qm;

endmodule

>>> sv/tlw_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlw_datapath
// Timer tables, wheel state, configuration registers, divider and the
// output stage with one held-back result for end-of-item marking.
// ----------------------------------------------------------------------------
module tlw_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_op,
    input  logic [5:0]                i_timer_id,
    input  logic [31:0]               i_delay_ms,
    input  logic [31:0]               i_now_ms,
    input  logic                      i_cfg_valid,
    input  logic [1:0]                i_cfg_index,
    input  logic [21:0]               i_cfg_data,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [5:0]                o_expired_id,
    output logic                      o_last,
    input  tlw_pkg::t_cmd             i_cmd,
    output tlw_pkg::t_stat            o_stat
);
    import tlw_pkg::*;

    logic [9:0]        r_micro;
    logic [15:0]       r_macro;
    logic [21:0]       r_scan;

    logic              r_op;
    logic [ID_W-1:0]   r_id;
    logic [31:0]       r_delay;
    logic [31:0]       r_now;

    logic [31:0]       r_fbase;
    logic [31:0]       r_cbase;
    logic [31:0]       r_lscan;
    logic [SLOT_W-1:0] r_fpos;
    logic [SLOT_W-1:0] r_cpos;

    logic [SLOT_W-1:0] r_slot;
    logic [LOOP_W-1:0] r_floop;
    logic [SLOT_W-1:0] r_ffin_pos;
    logic [31:0]       r_ffin_base;
    logic [31:0]       r_n;
    logic [SLOT_W-1:0] r_cfin_pos;
    logic [31:0]       r_cfin_base;

    logic [IDX_W-1:0]  r_t;
    t_lvl              r_lvl [NUM_TIMERS];
    logic [31:0]       dl_mem [NUM_TIMERS];
    logic [SLOT_W-1:0] pl_mem [NUM_TIMERS];
    logic [31:0]       r_rd_dl;
    logic [SLOT_W-1:0] r_rd_slot;
    t_lvl              r_rd_lvl;

    logic              r_out_valid;
    logic [ID_W-1:0]   r_out_id;
    logic              r_out_last;
    logic              r_pend_valid;
    logic [ID_W-1:0]   r_pend_id;

    logic [15:0]       w_micro_eff;
    logic [15:0]       w_macro_eff;
    logic [31:0]       w_dvd;
    logic [15:0]       w_dvs;
    logic [MOD_W-1:0]  w_mod;
    logic              w_busy;
    logic [31:0]       w_quot;
    logic [15:0]       w_rem;
    logic [SLOT_W-1:0] w_qmod;

    logic [31:0]       w_fd;
    logic [31:0]       w_fd_s;
    logic              w_fok;
    logic [31:0]       w_cd;
    logic [31:0]       w_cd_s;
    logic              w_cok;
    logic [31:0]       w_f;
    logic              w_f_fits;
    logic              w_c_fits;
    logic [31:0]       w_dl_now;
    logic              w_fire;
    logic              w_near;
    logic [31:0]       w_ov;
    logic              w_any_coarse;
    logic              w_hit;
    logic              w_out_free;
    logic              w_place_we;
    t_lvl              w_place_lvl;
    logic [SLOT_W-1:0] w_place_slot;

    assign w_micro_eff = (r_micro == '0) ? 16'd1 : {6'b0, r_micro};
    assign w_macro_eff = (r_macro == '0) ? 16'd1 : r_macro;

    always_comb begin
        case (i_cmd.div_sel)
            DIV_FINE_PASS: begin
                w_dvd = r_now - r_fbase;
                w_dvs = w_micro_eff;
                w_mod = FINE_M;
            end
            DIV_COARSE_PASS: begin
                w_dvd = r_now - r_cbase;
                w_dvs = w_macro_eff;
                w_mod = COARSE_M;
            end
            DIV_FILE_FINE: begin
                w_dvd = r_rd_dl - r_fbase;
                w_dvs = w_micro_eff;
                w_mod = FINE_M;
            end
            default: begin
                w_dvd = r_rd_dl - r_cbase;
                w_dvs = w_macro_eff;
                w_mod = COARSE_M;
            end
        endcase
    end

    tlw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .i_modulus  (w_mod),
        .o_busy     (w_busy),
        .o_quot     (w_quot),
        .o_rem      (w_rem),
        .o_qmod     (w_qmod)
    );

    assign w_fd   = r_now - r_fbase;
    assign w_fd_s = w_fd - {16'b0, w_micro_eff};
    assign w_fok  = (w_fd >= {16'b0, w_micro_eff}) && !w_fd_s[31];
    assign w_cd   = r_now - r_cbase;
    assign w_cd_s = w_cd - {16'b0, w_macro_eff};
    assign w_cok  = (w_cd >= {16'b0, w_macro_eff}) && !w_cd_s[31];

    assign w_f      = (w_quot == '0) ? 32'd1 : w_quot;
    assign w_f_fits = w_f < 32'(FINE_SLOTS);
    assign w_c_fits = w_quot < 32'(COARSE_SLOTS);

    assign w_dl_now = r_rd_dl - r_now;
    assign w_fire   = $signed({w_dl_now[31], w_dl_now}) < $signed({23'b0, r_micro});
    assign w_near   = $signed({w_dl_now[31], w_dl_now}) < $signed({11'b0, r_scan});
    assign w_ov     = r_now - r_lscan - {10'b0, r_scan};

    always_comb begin
        w_any_coarse = 1'b0;
        for (int k = 0; k < NUM_TIMERS; k++) begin
            if (r_lvl[k] == LVL_COARSE) begin
                w_any_coarse = 1'b1;
            end
        end
    end

    always_comb begin
        case (i_cmd.ctx)
            CTX_FINE:   w_hit = (r_rd_lvl == LVL_FINE) && (r_rd_slot == r_slot);
            CTX_COARSE: w_hit = (r_rd_lvl == LVL_COARSE) && (r_rd_slot == r_cpos);
            CTX_OVER:   w_hit = (r_rd_lvl == LVL_OVER) && w_near;
            default:    w_hit = 1'b0;
        endcase
    end

    always_comb begin
        w_place_we   = 1'b0;
        w_place_lvl  = LVL_OVER;
        w_place_slot = '0;
        if (i_cmd.file_a && w_f_fits) begin
            w_place_we   = 1'b1;
            w_place_lvl  = LVL_FINE;
            w_place_slot = mod_add(r_fpos, w_f[SLOT_W-1:0], FINE_M);
        end else if (i_cmd.file_b) begin
            w_place_we = 1'b1;
            if (w_c_fits) begin
                w_place_lvl  = LVL_COARSE;
                w_place_slot = mod_add(r_cpos, w_quot[SLOT_W-1:0], COARSE_M);
            end
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_micro <= MICRO_RST;
            r_macro <= MACRO_RST;
            r_scan  <= SCAN_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MICRO: r_micro <= i_cfg_data[9:0];
                CFG_MACRO: r_macro <= i_cfg_data[15:0];
                CFG_SCAN:  r_scan  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item) begin
            r_op    <= i_op;
            r_id    <= i_timer_id;
            r_delay <= i_delay_ms;
            r_now   <= i_now_ms;
        end
    end

    // wheel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fbase <= '0;
            r_cbase <= '0;
            r_lscan <= '0;
            r_fpos  <= '0;
            r_cpos  <= '0;
        end else begin
            if (i_cmd.fine_commit) begin
                r_fpos  <= r_ffin_pos;
                r_fbase <= r_ffin_base;
            end
            if (i_cmd.coarse_step) begin
                r_cbase <= r_cbase + {16'b0, w_macro_eff};
                r_cpos  <= (r_cpos == SLOT_W'(COARSE_SLOTS - 1)) ? '0 : r_cpos + 1'b1;
            end else if (i_cmd.coarse_commit) begin
                r_cbase <= r_cfin_base;
                r_cpos  <= r_cfin_pos;
            end
            if (i_cmd.ov_start) begin
                r_lscan <= r_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fine_setup) begin
            r_slot <= r_fpos;
            if (w_fok) begin
                r_floop     <= (w_quot >= 32'(FINE_SLOTS)) ?
                               LOOP_W'(FINE_SLOTS) : w_quot[LOOP_W-1:0];
                r_ffin_pos  <= mod_add(r_fpos, w_qmod, FINE_M);
                r_ffin_base <= r_now - {16'b0, w_rem};
            end else begin
                r_floop     <= '0;
                r_ffin_pos  <= r_fpos;
                r_ffin_base <= r_fbase;
            end
        end else if (i_cmd.fslot_adv) begin
            r_slot  <= (r_slot == SLOT_W'(FINE_SLOTS - 1)) ? '0 : r_slot + 1'b1;
            r_floop <= r_floop - 1'b1;
        end
        if (i_cmd.coarse_setup) begin
            if (w_cok) begin
                r_n         <= w_quot;
                r_cfin_pos  <= mod_add(r_cpos, w_qmod, COARSE_M);
                r_cfin_base <= r_now - {16'b0, w_rem};
            end else begin
                r_n         <= '0;
                r_cfin_pos  <= r_cpos;
                r_cfin_base <= r_cbase;
            end
        end else if (i_cmd.coarse_step) begin
            r_n <= r_n - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.arm_write) begin
            r_t <= r_id[IDX_W-1:0];
        end else if (i_cmd.fslot_adv || i_cmd.coarse_step || i_cmd.ov_start) begin
            r_t <= '0;
        end else if (i_cmd.t_inc) begin
            r_t <= r_t + 1'b1;
        end
    end

    // timer tables
    always_ff @(posedge i_clk) begin
        if (i_cmd.arm_write) begin
            dl_mem[r_id[IDX_W-1:0]] <= r_now + r_delay;
        end
        if (i_cmd.rd) begin
            r_rd_dl <= dl_mem[r_t];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_place_we) begin
            pl_mem[r_t] <= w_place_slot;
        end
        if (i_cmd.rd) begin
            r_rd_slot <= pl_mem[r_t];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_TIMERS; k++) begin
                r_lvl[k] <= LVL_NONE;
            end
            r_rd_lvl <= LVL_NONE;
        end else begin
            if (w_place_we) begin
                r_lvl[r_t] <= w_place_lvl;
            end else if (i_cmd.emit) begin
                r_lvl[r_t] <= LVL_NONE;
            end
            if (i_cmd.rd) begin
                r_rd_lvl <= r_lvl[r_t];
            end
        end
    end

    // output stage, one result held back until the next one or the end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            if (r_pend_valid) begin
                r_out_valid <= 1'b1;
                r_out_id    <= r_pend_id;
                r_out_last  <= 1'b0;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_pend_valid <= 1'b1;
            r_pend_id    <= ID_W'(r_t);
        end else if (i_cmd.flush && r_pend_valid) begin
            r_out_valid  <= 1'b1;
            r_out_id     <= r_pend_id;
            r_out_last   <= 1'b1;
            r_pend_valid <= 1'b0;
        end else if (r_out_valid && i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_expired_id = r_out_id;
    assign o_last       = r_out_last;

    assign o_stat.is_arm     = (t_op'(r_op) == OP_ARM);
    assign o_stat.arm_ok     = {26'b0, r_id} < 32'(NUM_TIMERS);
    assign o_stat.div_busy   = w_busy;
    assign o_stat.hit        = w_hit;
    assign o_stat.fire       = w_fire;
    assign o_stat.f_fits     = w_f_fits;
    assign o_stat.fpass_zero = (r_floop == '0);
    assign o_stat.cpass_end  = (r_n == '0) || !w_any_coarse;
    assign o_stat.ov_due     = !w_ov[31];
    assign o_stat.t_last     = (r_t == IDX_W'(NUM_TIMERS - 1));
    assign o_stat.emit_ok    = !r_pend_valid || w_out_free;
    assign o_stat.flush_ok   = !r_pend_valid || w_out_free;

endmodule

>>> sv/tlw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlw_ctrl
// Sequencer for arming, wheel passes, slot scans and timer re-filing.
// ----------------------------------------------------------------------------
module tlw_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tlw_pkg::t_stat i_stat,
    output tlw_pkg::t_cmd  o_cmd
);
    import tlw_pkg::*;

    t_state r_state, n_state;
    t_ctx   r_ctx, n_ctx;
    t_ret   r_ret, n_ret;
    t_state w_ret_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ctx   <= CTX_FINE;
            r_ret   <= RET_IDLE;
        end else begin
            r_state <= n_state;
            r_ctx   <= n_ctx;
            r_ret   <= n_ret;
        end
    end

    assign w_ret_state = (r_ret == RET_IDLE) ? S_IDLE : S_SCAN_NEXT;

    always_comb begin
        n_state    = r_state;
        n_ctx      = r_ctx;
        n_ret      = r_ret;
        o_cmd      = '0;
        o_cmd.ctx  = r_ctx;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.ld_item = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!i_stat.is_arm) begin
                    n_state = S_FDIV_GO;
                end else if (i_stat.arm_ok) begin
                    o_cmd.arm_write = 1'b1;
                    n_ret           = RET_IDLE;
                    n_state         = S_ARM_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ARM_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_FILE_A_GO;
            end
            S_FILE_A_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_FILE_FINE;
                n_state         = S_FILE_A_WAIT;
            end
            S_FILE_A_WAIT: begin
                o_cmd.div_sel = DIV_FILE_FINE;
                if (!i_stat.div_busy) begin
                    o_cmd.file_a = 1'b1;
                    n_state      = i_stat.f_fits ? w_ret_state : S_FILE_B_GO;
                end
            end
            S_FILE_B_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_FILE_COARSE;
                n_state         = S_FILE_B_WAIT;
            end
            S_FILE_B_WAIT: begin
                o_cmd.div_sel = DIV_FILE_COARSE;
                if (!i_stat.div_busy) begin
                    o_cmd.file_b = 1'b1;
                    n_state      = w_ret_state;
                end
            end
            S_FDIV_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_FINE_PASS;
                n_state         = S_FDIV_WAIT;
            end
            S_FDIV_WAIT: begin
                o_cmd.div_sel = DIV_FINE_PASS;
                if (!i_stat.div_busy) begin
                    o_cmd.fine_setup = 1'b1;
                    n_state          = S_FSLOT;
                end
            end
            S_FSLOT: begin
                if (i_stat.fpass_zero) begin
                    o_cmd.fine_commit = 1'b1;
                    n_state           = S_CDIV_GO;
                end else begin
                    o_cmd.fslot_adv = 1'b1;
                    n_ctx           = CTX_FINE;
                    n_state         = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (!i_stat.hit) begin
                    n_state = S_SCAN_NEXT;
                end else if (r_ctx == CTX_FINE || i_stat.fire) begin
                    if (i_stat.emit_ok) begin
                        o_cmd.emit = 1'b1;
                        n_state    = S_SCAN_NEXT;
                    end
                end else begin
                    n_ret   = RET_SCAN;
                    n_state = S_FILE_A_GO;
                end
            end
            S_SCAN_NEXT: begin
                if (i_stat.t_last) begin
                    case (r_ctx)
                        CTX_FINE:   n_state = S_FSLOT;
                        CTX_COARSE: n_state = S_CSTEP;
                        default:    n_state = S_DONE;
                    endcase
                end else begin
                    o_cmd.t_inc = 1'b1;
                    n_state     = S_SCAN_RD;
                end
            end
            S_CDIV_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_COARSE_PASS;
                n_state         = S_CDIV_WAIT;
            end
            S_CDIV_WAIT: begin
                o_cmd.div_sel = DIV_COARSE_PASS;
                if (!i_stat.div_busy) begin
                    o_cmd.coarse_setup = 1'b1;
                    n_state            = S_CSTEP;
                end
            end
            S_CSTEP: begin
                if (i_stat.cpass_end) begin
                    o_cmd.coarse_commit = 1'b1;
                    n_state             = S_OVCHK;
                end else begin
                    o_cmd.coarse_step = 1'b1;
                    n_ctx             = CTX_COARSE;
                    n_state           = S_SCAN_RD;
                end
            end
            S_OVCHK: begin
                if (i_stat.ov_due) begin
                    o_cmd.ov_start = 1'b1;
                    n_ctx          = CTX_OVER;
                    n_state        = S_SCAN_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.flush_ok) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> sv/two_level_timer_wheel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_timer_wheel
// Pool of 64 one-shot timers on a fine wheel, a coarse wheel and an
// overflow level; reports each expiry, marking the last one of a time request.
// ----------------------------------------------------------------------------
// One request at a time. An arm request runs a fine-wheel division and, when
// the timer lands beyond the fine wheel, a coarse-wheel division. A time
// request runs the fine pass division, a timer table walk per fine slot
// passed (at most 50), the coarse pass division, a walk per coarse slot
// visited while coarse timers remain, a re-filing per timer moved, and an
// overflow scan when one is due. Each walk reads the timer table through
// one read port, and the divider is bit-serial. Expiries queue behind a
// one-entry holding register and the output register; a slow consumer
// stalls the walk.
module two_level_timer_wheel (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [5:0]  i_timer_id,
    input  logic [31:0] i_delay_ms,
    input  logic [31:0] i_now_ms,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_expired_id,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [21:0] i_cfg_data
);
    import tlw_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    tlw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    tlw_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (i_op),
        .i_timer_id   (i_timer_id),
        .i_delay_ms   (i_delay_ms),
        .i_now_ms     (i_now_ms),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_expired_id (o_expired_id),
        .o_last       (o_last),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat)
    );

endmodule

>>> sv/tlw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlw_checker
// Port-level checks for the two-level timer wheel.
// ----------------------------------------------------------------------------
module tlw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [5:0]  o_expired_id,
    input logic        o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_expired_id) && $stable(o_last))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after a request was taken");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

endmodule

bind two_level_timer_wheel tlw_checker u_tlw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_expired_id (o_expired_id),
    .o_last       (o_last)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-level timer wheel. A scoreboard class keeps
// its own copy of the wheels and the timer table, predicts every expiry of
// each accepted request and checks the output stream in order, while tasks
// drive arm and time requests and register writes under several idle and
// stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import tlw_pkg::*;

    localparam int SETTLE_CYCLES = 20;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int RANDOM_PER_PHASE = 45;

    class wheel_scoreboard;
        logic [9:0]  micro_step;
        logic [15:0] macro_step;
        logic [21:0] scan_period;
        logic [31:0] deadline [NUM_TIMERS];
        t_lvl        level [NUM_TIMERS];
        logic [5:0]  slot [NUM_TIMERS];
        logic [31:0] fine_base;
        logic [31:0] fine_pos;
        logic [31:0] coarse_base;
        logic [31:0] coarse_pos;
        logic [31:0] last_scan;
        logic [6:0]  expiry_q [$];
        int          fired;
        int          errors;

        function void reset_state();
            micro_step = MICRO_RST;
            macro_step = MACRO_RST;
            scan_period = SCAN_RST;
            for (int t = 0; t < NUM_TIMERS; t++) begin
                deadline[t] = '0;
                level[t] = LVL_NONE;
                slot[t] = '0;
            end
            fine_base = '0;
            fine_pos = '0;
            coarse_base = '0;
            coarse_pos = '0;
            last_scan = '0;
            expiry_q.delete();
            errors = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [21:0] data);
            case (idx)
                CFG_MICRO: micro_step = data[9:0];
                CFG_MACRO: macro_step = data[15:0];
                CFG_SCAN: scan_period = data;
                default: ;
            endcase
        endfunction

        function logic [31:0] eff(logic [31:0] s);
            return (s == 0) ? 32'd1 : s;
        endfunction

        function logic [31:0] passes(logic [31:0] now, logic [31:0] base, logic [31:0] s);
            logic [31:0] d;
            d = now - base;
            if (d >= s && (d - s) < 32'h8000_0000) begin
                return d / s;
            end
            return 0;
        endfunction

        function void place(int id);
            logic [31:0] f;
            logic [31:0] c;
            f = (deadline[id] - fine_base) / eff(32'(micro_step));
            if (f == 0) f = 1;
            if (f < FINE_SLOTS) begin
                level[id] = LVL_FINE;
                slot[id] = 6'((fine_pos + f) % FINE_SLOTS);
                return;
            end
            c = (deadline[id] - coarse_base) / eff(32'(macro_step));
            if (c < COARSE_SLOTS) begin
                level[id] = LVL_COARSE;
                slot[id] = 6'((coarse_pos + c) % COARSE_SLOTS);
                return;
            end
            level[id] = LVL_OVER;
            slot[id] = '0;
        endfunction

        function void expire(int id);
            level[id] = LVL_NONE;
            expiry_q.push_back({6'(id), 1'b0});
            fired++;
        endfunction

        function void fire_or_place(int id, logic [31:0] now);
            logic [31:0] d;
            d = deadline[id] - now;
            if (longint'($signed(d)) < longint'(micro_step)) expire(id);
            else place(id);
        endfunction

        function void note_request(t_op op, logic [5:0] id, logic [31:0] delay,
                                   logic [31:0] now);
            logic [31:0] s;
            logic [31:0] n;
            logic [31:0] pos;
            logic [31:0] rem;
            logic [31:0] k;
            logic [31:0] d;
            bit          any;
            bit          snap [NUM_TIMERS];
            if (op == OP_ARM) begin
                deadline[id] = now + delay;
                place(id);
                return;
            end
            fired = 0;
            s = eff(32'(micro_step));
            n = passes(now, fine_base, s);
            for (int j = 1; j <= FINE_SLOTS && j <= n; j++) begin
                pos = (fine_pos + j) % FINE_SLOTS;
                for (int t = 0; t < NUM_TIMERS; t++)
                    if (level[t] == LVL_FINE && slot[t] == pos[5:0]) expire(t);
            end
            fine_pos = (fine_pos + n % FINE_SLOTS) % FINE_SLOTS;
            fine_base = fine_base + n * s;

            s = eff(32'(macro_step));
            n = passes(now, coarse_base, s);
            k = 0;
            while (k < n) begin
                any = 0;
                for (int t = 0; t < NUM_TIMERS; t++)
                    if (level[t] == LVL_COARSE) any = 1;
                if (!any) begin
                    rem = n - k;
                    coarse_base = coarse_base + rem * s;
                    coarse_pos = (coarse_pos + rem % COARSE_SLOTS) % COARSE_SLOTS;
                    break;
                end
                coarse_base = coarse_base + s;
                coarse_pos = (coarse_pos + 1) % COARSE_SLOTS;
                for (int t = 0; t < NUM_TIMERS; t++)
                    snap[t] = (level[t] == LVL_COARSE && slot[t] == coarse_pos[5:0]);
                for (int t = 0; t < NUM_TIMERS; t++)
                    if (snap[t]) fire_or_place(t, now);
                k++;
            end

            d = now - last_scan - 32'(scan_period);
            if ($signed(d) >= 0) begin
                last_scan = now;
                for (int t = 0; t < NUM_TIMERS; t++) snap[t] = (level[t] == LVL_OVER);
                for (int t = 0; t < NUM_TIMERS; t++) begin
                    d = deadline[t] - now;
                    if (snap[t] && longint'($signed(d)) < longint'(scan_period))
                        fire_or_place(t, now);
                end
            end
            if (fired > 0) expiry_q[$][0] = 1'b1;
        endfunction

        function void check_result(logic [5:0] id, logic last);
            logic [6:0] exp_r;
            if (expiry_q.size() == 0) begin
                $error("unexpected expiry: expired_id=%0d last=%0d", id, last);
                errors++;
                return;
            end
            exp_r = expiry_q.pop_front();
            if (id !== exp_r[6:1]) begin
                $error("expired_id: expected %0d, got %0d", exp_r[6:1], id);
                errors++;
            end
            if (last !== exp_r[0]) begin
                $error("last: expected %0d, got %0d", exp_r[0], last);
                errors++;
            end
        endfunction

        function int pending();
            return expiry_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_op;
    logic [5:0]  i_timer_id;
    logic [31:0] i_delay_ms;
    logic [31:0] i_now_ms;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [5:0]  o_expired_id;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [21:0] i_cfg_data;

    wheel_scoreboard sb;
    int          tx_idle_pct;
    int          rx_stall_pct;
    int          rx_hold;
    int          quiet_cycles;
    logic [31:0] cur_now;

    two_level_timer_wheel dut (.*);

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    task automatic send_req(t_op op, logic [5:0] id, logic [31:0] delay, logic [31:0] now);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_op = op;
        i_timer_id = id;
        i_delay_ms = delay;
        i_now_ms = now;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(op, id, delay, now);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [21:0] data);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0 || !o_in_ready) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic arm_random();
        logic [31:0] delay;
        logic [31:0] now;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 25) delay = $urandom_range(0, 60 * (sb.micro_step + 1));
        else if (r < 50) delay = $urandom_range(0, 70 * (sb.macro_step + 1));
        else if (r < 70) delay = $urandom_range(0, 2 * (sb.scan_period + 1));
        else if (r < 85) delay = $urandom;
        else if (r < 90) delay = 32'h0;
        else if (r < 95) delay = 32'hFFFF_FFFF;
        else delay = 32'h8000_0000;
        now = ($urandom_range(0, 9) == 0) ? $urandom : cur_now;
        send_req(OP_ARM, 6'($urandom_range(0, 63)), delay, now);
    endtask

    task automatic advance_random();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) cur_now = cur_now + $urandom_range(0, 3 * (sb.micro_step + 1));
        else if (r < 85) cur_now = cur_now + $urandom_range(0, 2 * (sb.macro_step + 1));
        else if (r < 95) cur_now = cur_now + $urandom_range(0, sb.scan_period + 1);
        else cur_now = $urandom;
        send_req(OP_TIME, 6'($urandom), $urandom, cur_now);
    endtask

    task automatic run_phase(logic [21:0] micro, logic [21:0] macro, logic [21:0] scan,
                             int tx_pct, int rx_pct, bit hold_rx, bit mid_pause);
        settle();
        write_cfg(CFG_MICRO, micro);
        write_cfg(CFG_MACRO, macro);
        write_cfg(CFG_SCAN, scan);
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        if (hold_rx) begin
            rx_hold = 4000;
            for (int t = 0; t < 24; t++)
                send_req(OP_ARM, 6'(t), $urandom_range(0, 40 * (sb.micro_step + 1)), cur_now);
        end
        for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
            if (mid_pause && k == RANDOM_PER_PHASE / 2) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
                while (sb.pending() != 0) @(posedge i_clk);
            end
            if ($urandom_range(0, 99) < 55) arm_random();
            else advance_random();
        end
    endtask

    // output side: check, then pick the next ready level
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_expired_id, o_last);
            @(negedge i_clk);
            if (rx_hold > 0) begin
                rx_hold--;
                i_out_ready = 1'b0;
            end else begin
                i_out_ready = ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        sb = new();
        sb.reset_state();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        rx_hold = 0;
        cur_now = '0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_op = OP_ARM;
        i_timer_id = '0;
        i_delay_ms = '0;
        i_now_ms = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MICRO;
        i_cfg_data = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset settings, each filing level, cancel, wrap and jumps
        send_req(OP_ARM, 6'd0, 32'd0, 32'd0);
        send_req(OP_ARM, 6'd63, 32'hFFFF_FFFF, 32'd0);
        send_req(OP_ARM, 6'd1, 32'd1500, 32'd0);
        send_req(OP_ARM, 6'd2, 32'd90000, 32'd0);
        send_req(OP_ARM, 6'd3, 32'd45, 32'd0);
        send_req(OP_ARM, 6'd4, 32'd45, 32'd0);
        send_req(OP_ARM, 6'd3, 32'd500, 32'd0);
        send_req(OP_TIME, 6'd63, 32'hFFFF_FFFF, 32'd0);
        send_req(OP_TIME, 6'd0, 32'd0, 32'd20);
        send_req(OP_TIME, 6'd0, 32'd0, 32'd60);
        send_req(OP_TIME, 6'd0, 32'd0, 32'd1000);
        send_req(OP_TIME, 6'd0, 32'd0, 32'd2100);
        send_req(OP_TIME, 6'd0, 32'd0, 32'd60000);
        send_req(OP_TIME, 6'd0, 32'd0, 32'd125000);
        send_req(OP_ARM, 6'd5, 32'd100, 32'hFFFF_FFF0);
        send_req(OP_TIME, 6'd0, 32'd0, 32'h8000_0000);
        send_req(OP_TIME, 6'd0, 32'd0, 32'h0000_0010);
        send_req(OP_TIME, 6'd0, 32'd0, 32'hFFFF_FFFF);
        cur_now = 32'hFFFF_FFFF;

        run_phase(22'd20, 22'd1000, 22'd60000, 0, 0, 0, 0);
        run_phase(22'd1, 22'd1, 22'd1, 50, 0, 0, 0);
        run_phase(22'd1000, 22'd60000, 22'd3600000, 0, 50, 0, 1);
        run_phase(22'd0, 22'd0, 22'd5, 35, 35, 0, 0);
        run_phase(22'd7, 22'd250, 22'd4000, 0, 0, 1, 0);
        run_phase(22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF, 35, 35, 0, 0);
        run_phase(22'd3, 22'd40, 22'd900, 0, 0, 0, 0);

        settle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

>>> two_level_timer_wheel.f
sv/tlw_pkg.sv
sv/tlw_div.sv
sv/tlw_datapath.sv
sv/tlw_ctrl.sv
sv/two_level_timer_wheel.sv
sv/tlw_checker.sv
tb/tb_top.sv
